// ===== hw/rtl/sdcbc_pkg.sv =====
package sdcbc_pkg;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  localparam logic CFG_IV_HIGH = 1'b0;
  localparam logic CFG_IV_LOW  = 1'b1;

  localparam logic [3:0] LAST_ROUND = 4'd15;

  localparam logic [7:0] MASK0 = 8'hFC;
  localparam logic [7:0] MASK1 = 8'hF3;
  localparam logic [7:0] MASK2 = 8'hCF;
  localparam logic [7:0] MASK3 = 8'h3F;

  typedef struct packed {
    logic [31:0]  l0;
    logic [31:0]  l1;
    logic [31:0]  r0;
    logic [31:0]  r1;
    logic [31:0]  c;
    logic [31:0]  d;
    logic [3:0]   rnd;
    logic [127:0] chain;
  } ring_t;

  localparam logic [7:0] SBOX1 [256] = '{
    8'hA9,8'h85,8'hD6,8'hD3,8'h54,8'h1D,8'hAC,8'h25,8'h5D,8'h43,8'h18,8'h1E,8'h51,8'hFC,8'hCA,8'h63,
    8'h28,8'h44,8'h20,8'h9D,8'hE0,8'hE2,8'hC8,8'h17,8'hA5,8'h8F,8'h03,8'h7B,8'hBB,8'h13,8'hD2,8'hEE,
    8'h70,8'h8C,8'h3F,8'hA8,8'h32,8'hDD,8'hF6,8'h74,8'hEC,8'h95,8'h0B,8'h57,8'h5C,8'h5B,8'hBD,8'h01,
    8'h24,8'h1C,8'h73,8'h98,8'h10,8'hCC,8'hF2,8'hD9,8'h2C,8'hE7,8'h72,8'h83,8'h9B,8'hD1,8'h86,8'hC9,
    8'h60,8'h50,8'hA3,8'hEB,8'h0D,8'hB6,8'h9E,8'h4F,8'hB7,8'h5A,8'hC6,8'h78,8'hA6,8'h12,8'hAF,8'hD5,
    8'h61,8'hC3,8'hB4,8'h41,8'h52,8'h7D,8'h8D,8'h08,8'h1F,8'h99,8'h00,8'h19,8'h04,8'h53,8'hF7,8'hE1,
    8'hFD,8'h76,8'h2F,8'h27,8'hB0,8'h8B,8'h0E,8'hAB,8'hA2,8'h6E,8'h93,8'h4D,8'h69,8'h7C,8'h09,8'h0A,
    8'hBF,8'hEF,8'hF3,8'hC5,8'h87,8'h14,8'hFE,8'h64,8'hDE,8'h2E,8'h4B,8'h1A,8'h06,8'h21,8'h6B,8'h66,
    8'h02,8'hF5,8'h92,8'h8A,8'h0C,8'hB3,8'h7E,8'hD0,8'h7A,8'h47,8'h96,8'hE5,8'h26,8'h80,8'hAD,8'hDF,
    8'hA1,8'h30,8'h37,8'hAE,8'h36,8'h15,8'h22,8'h38,8'hF4,8'hA7,8'h45,8'h4C,8'h81,8'hE9,8'h84,8'h97,
    8'h35,8'hCB,8'hCE,8'h3C,8'h71,8'h11,8'hC7,8'h89,8'h75,8'hFB,8'hDA,8'hF8,8'h94,8'h59,8'h82,8'hC4,
    8'hFF,8'h49,8'h39,8'h67,8'hC0,8'hCF,8'hD7,8'hB8,8'h0F,8'h8E,8'h42,8'h23,8'h91,8'h6C,8'hDB,8'hA4,
    8'h34,8'hF1,8'h48,8'hC2,8'h6F,8'h3D,8'h2D,8'h40,8'hBE,8'h3E,8'hBC,8'hC1,8'hAA,8'hBA,8'h4E,8'h55,
    8'h3B,8'hDC,8'h68,8'h7F,8'h9C,8'hD8,8'h4A,8'h56,8'h77,8'hA0,8'hED,8'h46,8'hB5,8'h2B,8'h65,8'hFA,
    8'hE3,8'hB9,8'hB1,8'h9F,8'h5E,8'hF9,8'hE6,8'hB2,8'h31,8'hEA,8'h6D,8'h5F,8'hE4,8'hF0,8'hCD,8'h88,
    8'h16,8'h3A,8'h58,8'hD4,8'h62,8'h29,8'h07,8'h33,8'hE8,8'h1B,8'h05,8'h79,8'h90,8'h6A,8'h2A,8'h9A
  };

  localparam logic [7:0] SBOX2 [256] = '{
    8'h38,8'hE8,8'h2D,8'hA6,8'hCF,8'hDE,8'hB3,8'hB8,8'hAF,8'h60,8'h55,8'hC7,8'h44,8'h6F,8'h6B,8'h5B,
    8'hC3,8'h62,8'h33,8'hB5,8'h29,8'hA0,8'hE2,8'hA7,8'hD3,8'h91,8'h11,8'h06,8'h1C,8'hBC,8'h36,8'h4B,
    8'hEF,8'h88,8'h6C,8'hA8,8'h17,8'hC4,8'h16,8'hF4,8'hC2,8'h45,8'hE1,8'hD6,8'h3F,8'h3D,8'h8E,8'h98,
    8'h28,8'h4E,8'hF6,8'h3E,8'hA5,8'hF9,8'h0D,8'hDF,8'hD8,8'h2B,8'h66,8'h7A,8'h27,8'h2F,8'hF1,8'h72,
    8'h42,8'hD4,8'h41,8'hC0,8'h73,8'h67,8'hAC,8'h8B,8'hF7,8'hAD,8'h80,8'h1F,8'hCA,8'h2C,8'hAA,8'h34,
    8'hD2,8'h0B,8'hEE,8'hE9,8'h5D,8'h94,8'h18,8'hF8,8'h57,8'hAE,8'h08,8'hC5,8'h13,8'hCD,8'h86,8'hB9,
    8'hFF,8'h7D,8'hC1,8'h31,8'hF5,8'h8A,8'h6A,8'hB1,8'hD1,8'h20,8'hD7,8'h02,8'h22,8'h04,8'h68,8'h71,
    8'h07,8'hDB,8'h9D,8'h99,8'h61,8'hBE,8'hE6,8'h59,8'hDD,8'h51,8'h90,8'hDC,8'h9A,8'hA3,8'hAB,8'hD0,
    8'h81,8'h0F,8'h47,8'h1A,8'hE3,8'hEC,8'h8D,8'hBF,8'h96,8'h7B,8'h5C,8'hA2,8'hA1,8'h63,8'h23,8'h4D,
    8'hC8,8'h9E,8'h9C,8'h3A,8'h0C,8'h2E,8'hBA,8'h6E,8'h9F,8'h5A,8'hF2,8'h92,8'hF3,8'h49,8'h78,8'hCC,
    8'h15,8'hFB,8'h70,8'h75,8'h7F,8'h35,8'h10,8'h03,8'h64,8'h6D,8'hC6,8'h74,8'hD5,8'hB4,8'hEA,8'h09,
    8'h76,8'h19,8'hFE,8'h40,8'h12,8'hE0,8'hBD,8'h05,8'hFA,8'h01,8'hF0,8'h2A,8'h5E,8'hA9,8'h56,8'h43,
    8'h85,8'h14,8'h89,8'h9B,8'hB0,8'hE5,8'h48,8'h79,8'h97,8'hFC,8'h1E,8'h82,8'h21,8'h8C,8'h1B,8'h5F,
    8'h77,8'h54,8'hB2,8'h1D,8'h25,8'h4F,8'h00,8'h46,8'hED,8'h58,8'h52,8'hEB,8'h7E,8'hDA,8'hC9,8'hFD,
    8'h30,8'h95,8'h65,8'h3C,8'hB6,8'hE4,8'hBB,8'h7C,8'h0E,8'h50,8'h39,8'h26,8'h32,8'h84,8'h69,8'h93,
    8'h37,8'hE7,8'h24,8'hA4,8'hCB,8'h53,8'h0A,8'h87,8'hD9,8'h4C,8'h83,8'h8F,8'hCE,8'h3B,8'h4A,8'hB7
  };

  function automatic logic [31:0] seed_g(input logic [31:0] x);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    a = SBOX1[x[7:0]];
    b = SBOX2[x[15:8]];
    c = SBOX1[x[23:16]];
    d = SBOX2[x[31:24]];
    return {a & MASK3, a & MASK2, a & MASK1, a & MASK0}
         ^ {b & MASK0, b & MASK3, b & MASK2, b & MASK1}
         ^ {c & MASK1, c & MASK0, c & MASK3, c & MASK2}
         ^ {d & MASK2, d & MASK1, d & MASK0, d & MASK3};
  endfunction

endpackage

// ===== hw/rtl/seed_cbc_block_decrypt_unit.sv =====
// A block word runs sixteen rounds in the ring, then its plaintext goes to out_r.
// Each round takes one pass through a three-stage ring, one G function per stage.
// Up to three blocks circulate interleaved; one enters while s2 holds none mid-round.
// A key word is taken only once no block is in the ring.
// Reset (synchronous, rst_n low) clears the IV, the chaining word and all valid flags.
// Round keys are undefined until written.
module seed_cbc_block_decrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_text_high,
  output logic [63:0] out_text_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import sdcbc_pkg::*;

  logic [31:0] key_even_mem [16];
  logic [31:0] key_odd_mem  [16];
  logic [31:0] key_even_r;
  logic [31:0] key_odd_r;
  logic [3:0]  key_addr;

  logic [63:0]  iv_high_r;
  logic [63:0]  iv_low_r;
  logic [127:0] prev_r;

  ring_t s0_r, s1_r, s2_r;
  ring_t s0_nxt, s1_nxt, s2_nxt;
  logic  s0_v_r, s1_v_r, s2_v_r;

  logic [127:0] out_r;
  logic [127:0] out_nxt;
  logic         out_valid_r;

  logic        cont;
  logic        fin;
  logic        adv;
  logic        ring_empty;
  logic        blk_acc;
  logic        key_acc;
  logic [31:0] g_d;
  logic [31:0] g_c;
  logic [31:0] nl0;
  logic [31:0] nl1;

  always_comb begin
    cont       = s2_v_r && (s2_r.rnd != '0);
    fin        = s2_v_r && (s2_r.rnd == '0);
    adv        = !fin || !out_valid_r || out_ready;
    ring_empty = !s0_v_r && !s1_v_r && !s2_v_r;
    in_ready   = (in_kind == KIND_BLOCK) ? (adv && !cont) : ring_empty;
    blk_acc    = in_valid && in_ready && (in_kind == KIND_BLOCK);
    key_acc    = in_valid && in_ready && (in_kind == KIND_KEY);
    key_addr   = cont ? (s2_r.rnd - 4'd1) : LAST_ROUND;

    g_d = seed_g(s2_r.d + s2_r.c);
    g_c = s2_r.c + g_d;
    nl0 = s2_r.l0 ^ g_c;
    nl1 = s2_r.l1 ^ g_d;

    s0_nxt = s2_r;
    if (cont) begin
      s0_nxt.l0  = s2_r.r0;
      s0_nxt.l1  = s2_r.r1;
      s0_nxt.r0  = nl0;
      s0_nxt.r1  = nl1;
      s0_nxt.rnd = s2_r.rnd - 4'd1;
    end else begin
      s0_nxt.l0    = in_block_high[63:32];
      s0_nxt.l1    = in_block_high[31:0];
      s0_nxt.r0    = in_block_low[63:32];
      s0_nxt.r1    = in_block_low[31:0];
      s0_nxt.rnd   = LAST_ROUND;
      s0_nxt.chain = in_restart ? {iv_high_r, iv_low_r} : prev_r;
    end

    s1_nxt   = s0_r;
    s1_nxt.c = s0_r.r0 ^ key_even_r;
    s1_nxt.d = seed_g(s1_nxt.c ^ s0_r.r1 ^ key_odd_r);

    s2_nxt   = s1_r;
    s2_nxt.c = seed_g(s1_r.c + s1_r.d);

    out_nxt = {nl0, nl1, s2_r.r0, s2_r.r1} ^ s2_r.chain;
  end

  always_ff @(posedge clk) begin
    if (key_acc) begin
      if (in_key_index[0]) begin
        key_odd_mem[in_key_index[4:1]] <= in_key_word;
      end else begin
        key_even_mem[in_key_index[4:1]] <= in_key_word;
      end
    end
    if (adv) begin
      key_even_r <= key_even_mem[key_addr];
      key_odd_r  <= key_odd_mem[key_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
    if (fin && adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      prev_r      <= '0;
    end else begin
      if (adv) begin
        s0_v_r <= cont || blk_acc;
        s1_v_r <= s0_v_r;
        s2_v_r <= s1_v_r;
      end
      if (fin && adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (blk_acc) begin
        prev_r <= {in_block_high, in_block_low};
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IV_HIGH: iv_high_r <= cfg_data;
          CFG_IV_LOW:  iv_low_r  <= cfg_data;
          default:     iv_high_r <= iv_high_r;
        endcase
      end
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_text_high = out_r[127:64];
  assign out_text_low  = out_r[63:0];

endmodule

// ===== dv/tb_seed_cbc_block_decrypt_unit.sv =====
module tb_seed_cbc_block_decrypt_unit;

  import sdcbc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_WORDS = 300;

  localparam bit [0:255][7:0] SUB1 = {
    128'hA985D6D3541DAC255D43181E51FCCA63, 128'h2844209DE0E2C817A58F037BBB13D2EE,
    128'h708C3FA832DDF674EC950B575C5BBD01, 128'h241C739810CCF2D92CE772839BD186C9,
    128'h6050A3EB0DB69E4FB75AC678A612AFD5, 128'h61C3B441527D8D081F9900190453F7E1,
    128'hFD762F27B08B0EABA26E934D697C090A, 128'hBFEFF3C58714FE64DE2E4B1A06216B66,
    128'h02F5928A0CB37ED07A4796E52680ADDF, 128'hA13037AE36152238F4A7454C81E98497,
    128'h35CBCE3C7111C78975FBDAF8945982C4, 128'hFF493967C0CFD7B80F8E4223916CDBA4,
    128'h34F148C26F3D2D40BE3EBCC1AABA4E55, 128'h3BDC687F9CD84A5677A0ED46B52B65FA,
    128'hE3B9B19F5EF9E6B231EA6D5FE4F0CD88, 128'h163A58D462290733E81B0579906A2A9A
  };

  localparam bit [0:255][7:0] SUB2 = {
    128'h38E82DA6CFDEB3B8AF6055C7446F6B5B, 128'hC36233B529A0E2A7D39111061CBC364B,
    128'hEF886CA817C416F4C245E1D63F3D8E98, 128'h284EF63EA5F90DDFD82B667A272FF172,
    128'h42D441C07367AC8BF7AD801FCA2CAA34, 128'hD20BEEE95D9418F857AE08C513CD86B9,
    128'hFF7DC131F58A6AB1D120D70222046871, 128'h07DB9D9961BEE659DD5190DC9AA3ABD0,
    128'h810F471AE3EC8DBF967B5CA2A163234D, 128'hC89E9C3A0C2EBA6E9F5AF292F34978CC,
    128'h15FB70757F351003646DC674D5B4EA09, 128'h7619FE4012E0BD05FA01F02A5EA95643,
    128'h8514899BB0E5487997FC1E82218C1B5F, 128'h7754B21D254F0046ED5852EB7EDAC9FD,
    128'h3095653CB6E4BB7C0E50392632846993, 128'h37E724A4CB530A87D94C838FCE3B4AB7
  };

  localparam bit [0:3][7:0] MIX_MASK = {8'hFC, 8'hF3, 8'hCF, 8'h3F};

  typedef struct {
    logic        kind;
    logic [4:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        restart;
  } cipher_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [4:0]  in_key_index = '0;
  logic [31:0] in_key_word = '0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_text_high;
  logic [63:0] out_text_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  cipher_item_t pending[$];
  logic [127:0] plain_q[$];
  logic [31:0]  key_mem [32];
  logic [127:0] chain_prev = '0;
  logic [63:0]  iv_high_copy = '0;
  logic [63:0]  iv_low_copy = '0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   in_gap = 0;
  int   in_calm = 0;
  int   out_hold = 0;
  int   out_calm = 0;
  int   quiet = 0;
  int   bad_words = 0;

  seed_cbc_block_decrypt_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_key_index  (in_key_index),
    .in_key_word   (in_key_word),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_high (out_text_high),
    .out_text_low  (out_text_low),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] g_mix(input logic [31:0] x);
    logic [7:0]  sb [4];
    logic [31:0] y;
    sb[0] = SUB1[x[7:0]];
    sb[1] = SUB2[x[15:8]];
    sb[2] = SUB1[x[23:16]];
    sb[3] = SUB2[x[31:24]];
    y = '0;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        y[8*k +: 8] = y[8*k +: 8] ^ (sb[2'(j)] & MIX_MASK[2'((j + k) % 4)]);
      end
    end
    return y;
  endfunction

  // Sixteen rounds with the round keys taken last to first, no swap after round zero.
  function automatic logic [127:0] open_block(input logic [127:0] ct);
    logic [31:0] l0, l1, r0, r1, c, d, t;
    {l0, l1, r0, r1} = ct;
    for (int r = 15; r >= 0; r--) begin
      c = r0 ^ key_mem[5'(2*r)];
      d = r1 ^ key_mem[5'(2*r + 1)];
      d = g_mix(d ^ c);
      c = g_mix(c + d);
      d = g_mix(d + c);
      c = c + d;
      l0 = l0 ^ c;
      l1 = l1 ^ d;
      if (r != 0) begin
        t = l0; l0 = r0; r0 = t;
        t = l1; l1 = r1; r1 = t;
      end
    end
    return {l0, l1, r0, r1};
  endfunction

  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_data64();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_key_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_key(input logic [4:0] idx, input logic [31:0] value);
    cipher_item_t it;
    it.kind = KIND_KEY;
    it.key_index = idx;
    it.key_word = value;
    it.block_high = pick_data64();
    it.block_low = pick_data64();
    it.restart = 1'($urandom_range(0, 1));
    pending.push_back(it);
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo, input logic rs);
    cipher_item_t it;
    it.kind = KIND_BLOCK;
    it.key_index = 5'($urandom_range(0, 31));
    it.key_word = $urandom;
    it.block_high = hi;
    it.block_low = lo;
    it.restart = rs;
    pending.push_back(it);
  endtask

  // Mostly chained buffers with random content; key reloads land in the middle of them.
  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_key(5'($urandom_range(0, 31)), pick_key_word());
      end else begin
        queue_block(pick_data64(), pick_data64(), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic write_iv(input logic idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_IV_HIGH) begin
      iv_high_copy = value;
    end else begin
      iv_low_copy = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || plain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_in
    cipher_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending.size() > 0) begin
        nxt = pending.pop_front();
        in_valid <= 1'b1;
        in_kind <= nxt.kind;
        in_key_index <= nxt.key_index;
        in_key_word <= nxt.key_word;
        in_block_high <= nxt.block_high;
        in_block_low <= nxt.block_low;
        in_restart <= nxt.restart;
        in_gap <= pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_out_ready
    int hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (out_took || $urandom_range(0, 24) == 0) begin
      hold = pick_gap(out_calm);
      out_ready <= (hold == 0);
      out_hold <= (hold > 0) ? hold - 1 : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    logic [127:0] want;
    logic         in_fire;
    logic         out_fire;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      quiet <= 0;
    end else begin
      in_fire = in_valid && in_ready;
      out_fire = out_valid && out_ready;
      in_took <= in_fire;
      out_took <= out_fire;
      if (in_fire) begin
        if (in_kind == KIND_KEY) begin
          key_mem[in_key_index] = in_key_word;
        end else begin
          want = open_block({in_block_high, in_block_low})
               ^ (in_restart ? {iv_high_copy, iv_low_copy} : chain_prev);
          plain_q.push_back(want);
          chain_prev = {in_block_high, in_block_low};
        end
      end
      if (out_fire) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected result word text_high %h text_low %h",
                   $time, out_text_high, out_text_low);
          bad_words = bad_words + 1;
        end else begin
          want = plain_q.pop_front();
          if (out_text_high !== want[127:64]) begin
            $display("%0t: text_high expected %h actual %h",
                     $time, want[127:64], out_text_high);
            bad_words = bad_words + 1;
          end
          if (out_text_low !== want[63:0]) begin
            $display("%0t: text_low expected %h actual %h",
                     $time, want[63:0], out_text_low);
            bad_words = bad_words + 1;
          end
        end
      end
      if (in_fire || out_fire || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_seed_cbc_block_decrypt_unit: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every round key is loaded before the first block.
    for (int i = 0; i < 32; i++) begin
      case (i)
        0, 30:   queue_key(5'(i), 32'h0000_0000);
        1, 31:   queue_key(5'(i), 32'hFFFF_FFFF);
        default: queue_key(5'(i), $urandom);
      endcase
    end
    queue_block('0, '0, 1'b0);
    queue_block('1, '1, 1'b0);
    queue_block(pick_data64(), pick_data64(), 1'b1);
    queue_key(5'd31, $urandom);
    queue_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    queue_block('1, '0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_iv(CFG_IV_HIGH, '1);
          write_iv(CFG_IV_LOW, '1);
          queue_block(pick_data64(), pick_data64(), 1'b0);
          queue_block(pick_data64(), pick_data64(), 1'b1);
        end
        1: begin
          write_iv(CFG_IV_HIGH, '0);
          write_iv(CFG_IV_LOW, '0);
        end
        2: begin
          write_iv(CFG_IV_HIGH, '1);
          write_iv(CFG_IV_LOW, '0);
        end
        3: begin
          write_iv(CFG_IV_HIGH, {$urandom, $urandom});
          write_iv(CFG_IV_LOW, {$urandom, $urandom});
        end
        4: begin
          write_iv(CFG_IV_LOW, {$urandom, $urandom});
        end
        default: begin
          write_iv(CFG_IV_HIGH, '0);
          write_iv(CFG_IV_LOW, '1);
        end
      endcase
      queue_block(pick_data64(), pick_data64(), 1'b1);
      queue_random(PHASE_WORDS);
    end

    settle();
    if (bad_words == 0 && plain_q.size() == 0) begin
      $display("tb_seed_cbc_block_decrypt_unit: PASS");
    end else begin
      $display("tb_seed_cbc_block_decrypt_unit: FAIL");
    end
    $finish;
  end

endmodule
